FILE: rtl/sqd_pkg.sv
// shared constants, payload types, state codes and ring helpers of the dispatcher
package sqd_pkg;

    localparam int NUM_QUEUES      = 4;
    localparam int QUEUE_DEPTH     = 16;
    localparam int MINUTES_PER_HOUR = 60;

    localparam int QIDX_W = $clog2(NUM_QUEUES);
    localparam int HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * QUEUE_DEPTH);
    localparam int SLOT_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

    localparam int TIME_W     = 16;
    localparam int TOTAL_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIVCNT_W   = $clog2(DIVIDEND_W);

    localparam logic [1:0] OP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_DEPART = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BACKWARDS = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_CUST   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_ARRIVE,
        S_DEP_RD,
        S_DEP_ACC,
        S_CL_RD,
        S_CL_ACC,
        S_DIV_AVG,
        S_DIV_HM,
        S_DONE
    } sqd_state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] now_minutes;
        logic [1:0]        window_index;
    } evt_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         assigned_window;
        logic               had_to_wait;
        logic [TIME_W-1:0]  stay_minutes;
        logic [TOTAL_W-1:0] total_minutes;
        logic [COUNT_W-1:0] customer_count;
        logic [15:0]        avg_hours;
        logic [5:0]         avg_minutes;
    } res_t;

    function automatic logic [HEAD_W-1:0] ring_add(input logic [HEAD_W-1:0] head,
                                                   input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return HEAD_W'(s);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                    input logic [HEAD_W-1:0] pos);
        return SLOT_W'(q) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(pos);
    endfunction

endpackage

FILE: rtl/sqd_channels.sv
// valid/ready channel interfaces for event and result beats
interface sqd_evt_if;
    import sqd_pkg::*;
    logic valid;
    logic ready;
    evt_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sqd_res_if;
    import sqd_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sqd_store.sv
// arrival time memory, one write port and one registered read port
module sqd_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [sqd_pkg::SLOT_W-1:0] waddr,
    input  logic [sqd_pkg::TIME_W-1:0] wdata,
    input  logic [sqd_pkg::SLOT_W-1:0] raddr,
    output logic [sqd_pkg::TIME_W-1:0] rdata
);
    import sqd_pkg::*;

    logic [TIME_W-1:0] mem [NUM_QUEUES*QUEUE_DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sqd_div.sv
// restoring divider, one quotient bit per cycle
module sqd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sqd_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [sqd_pkg::DIVISOR_W-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [sqd_pkg::DIVIDEND_W-1:0] quotient,
    output logic [sqd_pkg::DIVISOR_W-1:0]  remainder
);
    import sqd_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVCNT_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = DIVISOR_W'(trial);
            end
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/shortest_queue_dispatch_latency.sv
// Join-shortest-queue dispatcher: one event beat in, one result beat out per event. An event is
// taken only while the sequencer is idle; a finished result waits in the output register and
// does not hold back the next event. Steps per event, from accept to result: an arrival scans
// every queue, one queue per cycle, for the shortest; a departure makes one memory read; a
// close walks the arrival memory over the customers still queued and then, if any customer
// was counted, makes two passes of the 32-step divider (total / count, then average / 60); a
// backwards timestamp goes straight from the check step to the result.
module shortest_queue_dispatch_latency (
    input logic        clk,
    input logic        rst_n,
    sqd_evt_if.sink    evt,
    sqd_res_if.source  res
);
    import sqd_pkg::*;

    localparam logic [QIDX_W-1:0] LAST_Q = QIDX_W'(NUM_QUEUES - 1);

    sqd_state_t         state_reg, state_next;
    logic [OCC_W-1:0]   occ_reg [NUM_QUEUES];
    logic [OCC_W-1:0]   occ_next [NUM_QUEUES];
    logic [HEAD_W-1:0]  head_reg [NUM_QUEUES];
    logic [HEAD_W-1:0]  head_next [NUM_QUEUES];
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [QIDX_W-1:0]  q_reg, q_next;
    logic [QIDX_W-1:0]  pick_reg, pick_next;
    logic [OCC_W-1:0]   min_reg, min_next;
    logic [OCC_W-1:0]   k_reg, k_next;
    logic [1:0]         op_reg, op_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [1:0]         win_reg, win_next;
    logic [2:0]         status_reg, status_next;
    logic [1:0]         assigned_reg, assigned_next;
    logic               waited_reg, waited_next;
    logic [TIME_W-1:0]  stay_reg, stay_next;
    logic [15:0]        hours_reg, hours_next;
    logic [5:0]         mins_reg, mins_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_data_reg, out_data_next;

    logic [OCC_W-1:0]      occ_cur;
    logic [HEAD_W-1:0]     head_cur;
    logic [TIME_W-1:0]     diff;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [SLOT_W-1:0]     mem_raddr;
    logic [TIME_W-1:0]     mem_rdata;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic [DIVISOR_W-1:0]  div_remainder;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W+1)'(b);
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    sqd_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (now_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sqd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                occ_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
            last_time_reg <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            head_reg      <= head_next;
            last_time_reg <= last_time_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            q_reg         <= q_next;
            k_reg         <= k_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg     <= pick_next;
        min_reg      <= min_next;
        now_reg      <= now_next;
        win_reg      <= win_next;
        status_reg   <= status_next;
        assigned_reg <= assigned_next;
        waited_reg   <= waited_next;
        stay_reg     <= stay_next;
        hours_reg    <= hours_next;
        mins_reg     <= mins_next;
        out_data_reg <= out_data_next;
    end

    assign occ_cur   = occ_reg[q_reg];
    assign head_cur  = head_reg[q_reg];
    assign diff      = now_reg - mem_rdata;
    assign mem_waddr = slot_addr(q_reg, ring_add(head_cur, occ_cur));
    assign mem_raddr = slot_addr(q_reg, ring_add(head_cur, k_reg));
    assign evt.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        head_next      = head_reg;
        last_time_next = last_time_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        q_next         = q_reg;
        pick_next      = pick_reg;
        min_next       = min_reg;
        k_next         = k_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        win_next       = win_reg;
        status_next    = status_reg;
        assigned_next  = assigned_reg;
        waited_next    = waited_reg;
        stay_next      = stay_reg;
        hours_next     = hours_reg;
        mins_next      = mins_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        div_dividend   = total_reg;
        div_divisor    = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    op_next       = evt.data.opcode;
                    now_next      = evt.data.now_minutes;
                    win_next      = evt.data.window_index;
                    status_next   = ST_OK;
                    assigned_next = '0;
                    waited_next   = 1'b0;
                    stay_next     = '0;
                    hours_next    = '0;
                    mins_next     = '0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                k_next = '0;
                q_next = '0;
                if (now_reg < last_time_reg)
                begin
                    status_next = ST_BACKWARDS;
                    state_next  = S_DONE;
                end
                else
                begin
                    last_time_next = now_reg;
                    case (op_reg)
                        OP_ARRIVE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_DEPART:
                        begin
                            if (int'(win_reg) >= NUM_QUEUES)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                q_next     = QIDX_W'(win_reg);
                                state_next = S_DEP_RD;
                            end
                        end
                        OP_CLOSE:
                        begin
                            state_next = S_CL_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // first strict minimum, so the first empty queue wins
                if (q_reg == '0 || occ_cur < min_reg)
                begin
                    pick_next = q_reg;
                    min_next  = occ_cur;
                end
                if (q_reg == LAST_Q)
                begin
                    q_next     = pick_next;
                    state_next = S_ARRIVE;
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                end
            end
            S_ARRIVE:
            begin
                if (occ_cur >= OCC_W'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we          = 1'b1;
                    waited_next     = (occ_cur != '0);
                    occ_next[q_reg] = occ_cur + 1'b1;
                    assigned_next   = 2'(q_reg);
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DEP_RD:
            begin
                if (occ_cur == '0)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_DEP_ACC;
                end
            end
            S_DEP_ACC:
            begin
                stay_next        = diff;
                total_next       = sat_add(total_reg, diff);
                head_next[q_reg] = ring_add(head_cur, OCC_W'(1));
                occ_next[q_reg]  = occ_cur - 1'b1;
                state_next       = S_DONE;
            end
            S_CL_RD:
            begin
                if (k_reg >= occ_cur)
                begin
                    occ_next[q_reg]  = '0;
                    head_next[q_reg] = '0;
                    k_next           = '0;
                    if (q_reg == LAST_Q)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_NO_CUST;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV_AVG;
                        end
                    end
                    else
                    begin
                        q_next = q_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CL_ACC;
                end
            end
            S_CL_ACC:
            begin
                total_next = sat_add(total_reg, diff);
                state_next = S_CL_RD;
            end
            S_DIV_AVG:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = div_quotient;
                    div_divisor  = DIVISOR_W'(MINUTES_PER_HOUR);
                    state_next   = S_DIV_HM;
                end
            end
            S_DIV_HM:
            begin
                if (div_done)
                begin
                    if (div_quotient > DIVIDEND_W'(16'hFFFF))
                    begin
                        hours_next = 16'hFFFF;
                        mins_next  = 6'(MINUTES_PER_HOUR - 1);
                    end
                    else
                    begin
                        hours_next = div_quotient[15:0];
                        mins_next  = 6'(div_remainder);
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = status_reg;
                    out_data_next.assigned_window = assigned_reg;
                    out_data_next.had_to_wait     = waited_reg;
                    out_data_next.stay_minutes    = stay_reg;
                    out_data_next.total_minutes   = total_reg;
                    out_data_next.customer_count  = count_reg;
                    out_data_next.avg_hours       = hours_reg;
                    out_data_next.avg_minutes     = mins_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.ready |=> state_reg == S_CHECK)
        else $error("accepted beat did not enter the check step");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_cur <= OCC_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("customer count went down");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("running total went down");
`endif

endmodule

FILE: tb/sv/shortest_queue_dispatch_latency_tb.sv
// self-checking bench for the shortest-queue dispatcher: event stream with randomized pacing
`timescale 1ns / 100ps

module shortest_queue_dispatch_latency_tb;

    import sqd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_EVENTS = 900;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class dispatch_scoreboard;
        logic [TIME_W-1:0]  stamp [NUM_QUEUES][QUEUE_DEPTH];
        logic [HEAD_W-1:0]  head [NUM_QUEUES];
        logic [OCC_W-1:0]   occ [NUM_QUEUES];
        logic [TIME_W-1:0]  last_t;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
        res_t               pending_reports[$];
        int                 errors;
        int                 checked;
        int                 status_seen [5];

        function new();
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head[q] = '0;
                occ[q]  = '0;
            end
            last_t  = '0;
            total   = '0;
            count   = '0;
            errors  = 0;
            checked = 0;
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
        endfunction

        function void add_stay(logic [TIME_W-1:0] amt);
            logic [TOTAL_W:0] s;
            s = {1'b0, total} + (TOTAL_W+1)'(amt);
            total = s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
        endfunction

        function res_t dispatch(evt_t e);
            res_t               r;
            int                 pick;
            bit                 found;
            logic [1:0]         w;
            logic [TIME_W-1:0]  t;
            logic [TOTAL_W-1:0] avg;
            logic [TOTAL_W-1:0] hrs;
            r = '0;
            if (e.now_minutes < last_t)
            begin
                r.status = ST_BACKWARDS;
            end
            else
            begin
                last_t = e.now_minutes;
                case (e.opcode)
                    OP_ARRIVE:
                    begin
                        pick  = 0;
                        found = 0;
                        for (int q = 0; q < NUM_QUEUES; q++)
                        begin
                            if (!found && occ[q] == 0)
                            begin
                                pick  = q;
                                found = 1;
                            end
                        end
                        if (!found)
                        begin
                            for (int q = 1; q < NUM_QUEUES; q++)
                            begin
                                if (occ[q] < occ[pick])
                                    pick = q;
                            end
                        end
                        if (occ[pick] >= QUEUE_DEPTH)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            stamp[pick][(int'(head[pick]) + int'(occ[pick])) % QUEUE_DEPTH] =
                                e.now_minutes;
                            r.had_to_wait     = (occ[pick] != 0);
                            r.assigned_window = 2'(pick);
                            occ[pick]++;
                            if (count != '1)
                                count++;
                        end
                    end
                    OP_DEPART:
                    begin
                        w = e.window_index;
                        if (int'(w) >= NUM_QUEUES || occ[w] == 0)
                        begin
                            r.status = ST_EMPTY;
                        end
                        else
                        begin
                            t = stamp[w][head[w]];
                            r.stay_minutes = e.now_minutes - t;
                            add_stay(r.stay_minutes);
                            head[w] = HEAD_W'((int'(head[w]) + 1) % QUEUE_DEPTH);
                            occ[w]--;
                        end
                    end
                    OP_CLOSE:
                    begin
                        for (int q = 0; q < NUM_QUEUES; q++)
                        begin
                            for (int k = 0; k < occ[q]; k++)
                            begin
                                t = stamp[q][(int'(head[q]) + k) % QUEUE_DEPTH];
                                add_stay(e.now_minutes - t);
                            end
                            occ[q]  = '0;
                            head[q] = '0;
                        end
                        if (count == 0)
                        begin
                            r.status = ST_NO_CUST;
                        end
                        else
                        begin
                            avg = total / count;
                            hrs = avg / MINUTES_PER_HOUR;
                            if (hrs > 32'hFFFF)
                            begin
                                r.avg_hours   = 16'hFFFF;
                                r.avg_minutes = 6'd59;
                            end
                            else
                            begin
                                r.avg_hours   = 16'(hrs);
                                r.avg_minutes = 6'(avg % MINUTES_PER_HOUR);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.total_minutes  = total;
            r.customer_count = count;
            return r;
        endfunction

        function void note_event(evt_t e);
            pending_reports.push_back(dispatch(e));
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no event waiting for it");
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            if (int'(want.status) < 5)
                status_seen[want.status]++;
            compare("status", want.status, got.status);
            compare("assigned_window", want.assigned_window, got.assigned_window);
            compare("had_to_wait", want.had_to_wait, got.had_to_wait);
            compare("stay_minutes", want.stay_minutes, got.stay_minutes);
            compare("total_minutes", want.total_minutes, got.total_minutes);
            compare("customer_count", want.customer_count, got.customer_count);
            compare("avg_hours", want.avg_hours, got.avg_hours);
            compare("avg_minutes", want.avg_minutes, got.avg_minutes);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sqd_evt_if evt_ch ();
    sqd_res_if res_ch ();

    shortest_queue_dispatch_latency uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    dispatch_scoreboard sb;
    int events_sent;
    int burst_left;
    int quiet_left;
    int cycle_count;
    bit hold_req;
    bit hold_done;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function evt_t build_event(logic [1:0] op, logic [TIME_W-1:0] t, logic [1:0] w);
        evt_t e;
        e.opcode       = op;
        e.now_minutes  = t;
        e.window_index = w;
        return e;
    endfunction

    function logic [TIME_W-1:0] later_time();
        int unsigned t;
        t = sb.last_t;
        if ($urandom_range(0, 3) != 0)
            t += $urandom_range(1, 130);
        return (t > 32'hFFFF) ? 16'hFFFF : 16'(t);
    endfunction

    task offer_event(input evt_t e);
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= e;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        sb.note_event(e);
        events_sent++;
        if (quiet_left > 0)
        begin
            quiet_left--;
        end
        else
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                begin
                    evt_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end
    endtask

    task random_event(input bit arrivals_only);
        int r;
        int open_q[$];
        r = $urandom_range(0, 99);
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (sb.occ[q] != 0)
                open_q.push_back(q);
        end
        if (r < 4)
        begin
            offer_event(build_event(OP_UNUSED, later_time(), 2'($urandom)));
        end
        else if (r < 8 && sb.last_t != 0)
        begin
            offer_event(build_event(2'($urandom), 16'($urandom_range(0, sb.last_t - 1)),
                                    2'($urandom)));
        end
        else if (r < 11)
        begin
            offer_event(build_event(OP_DEPART, later_time(), 2'($urandom)));
        end
        else if (!arrivals_only && open_q.size() != 0 && $urandom_range(0, 99) < 45)
        begin
            offer_event(build_event(OP_DEPART, later_time(),
                                    2'(open_q[$urandom_range(0, open_q.size() - 1)])));
        end
        else
        begin
            offer_event(build_event(OP_ARRIVE, later_time(), 2'($urandom)));
        end
    endtask

    // result side: stall patterns plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        res_ch.ready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.data);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= (mode_left % 3 != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("shortest_queue_dispatch_latency_tb: errors");
        $finish;
    end

    initial
    begin
        int base;
        sb           = new();
        rst_n        = 1'b0;
        evt_ch.valid <= 1'b0;
        evt_ch.data  <= '0;
        events_sent  = 0;
        burst_left   = 1;
        quiet_left   = 0;
        cycle_count  = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no customers yet, empty window, unused opcode
        offer_event(build_event(OP_CLOSE, 16'd0, 2'd0));
        offer_event(build_event(OP_DEPART, 16'd0, 2'd0));
        offer_event(build_event(OP_UNUSED, 16'd1, 2'd3));
        // first-empty placement, then shortest with ties to the low index
        offer_event(build_event(OP_ARRIVE, 16'd5, 2'd0));
        offer_event(build_event(OP_ARRIVE, 16'd5, 2'd3));
        offer_event(build_event(OP_ARRIVE, 16'd6, 2'd1));
        offer_event(build_event(OP_ARRIVE, 16'd7, 2'd2));
        offer_event(build_event(OP_ARRIVE, 16'd8, 2'd0));
        offer_event(build_event(OP_ARRIVE, 16'd9, 2'd0));
        offer_event(build_event(OP_DEPART, 16'd10, 2'd3));
        offer_event(build_event(OP_ARRIVE, 16'd11, 2'd0));
        offer_event(build_event(OP_DEPART, 16'd12, 2'd0));
        offer_event(build_event(OP_ARRIVE, 16'd13, 2'd1));
        // timestamps going backwards, then departures until a window runs empty, and a close
        offer_event(build_event(OP_ARRIVE, 16'd4, 2'd0));
        offer_event(build_event(OP_CLOSE, 16'd3, 2'd2));
        offer_event(build_event(OP_DEPART, 16'd20, 2'd1));
        offer_event(build_event(OP_DEPART, 16'd21, 2'd2));
        offer_event(build_event(OP_DEPART, 16'd21, 2'd2));
        offer_event(build_event(OP_CLOSE, 16'd30, 2'd1));

        base = events_sent;
        while (events_sent - base < RANDOM_EVENTS)
        begin
            if (!hold_done && events_sent - base > RANDOM_EVENTS / 2)
            begin
                hold_req   = 1'b1;
                hold_done  = 1'b1;
                quiet_left = 40;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(68, 80)) random_event(1'b1);
                repeat ($urandom_range(0, 20)) random_event(1'b0);
            end
            else
            begin
                repeat ($urandom_range(5, 50)) random_event(1'b0);
            end
            if ($urandom_range(0, 4) != 0)
                offer_event(build_event(OP_CLOSE, later_time(), 2'($urandom)));
        end

        // top of the time range
        offer_event(build_event(OP_ARRIVE, 16'hFFFF, 2'd3));
        offer_event(build_event(OP_ARRIVE, 16'hFFFF, 2'd0));
        offer_event(build_event(OP_CLOSE, 16'hFFFF, 2'd2));
        offer_event(build_event(OP_DEPART, 16'h0000, 2'd3));

        evt_ch.valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d events taken, %0d result beats compared", events_sent, sb.checked);
        $display("status mix ok/backwards/empty/full/no-customers: %0d/%0d/%0d/%0d/%0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
        begin
            $display("shortest_queue_dispatch_latency_tb: clean");
        end
        else
        begin
            $display("shortest_queue_dispatch_latency_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/sqd_pkg.sv
rtl/sqd_channels.sv
rtl/sqd_store.sv
rtl/sqd_div.sv
rtl/shortest_queue_dispatch_latency.sv
tb/sv/shortest_queue_dispatch_latency_tb.sv
